/* rtl/spr_pkg.sv */
// Shared types and constants for the SPI sync poll responder.
// No dependencies; every other file in rtl imports this package.
package spr_pkg;

    localparam int BUFFER_LEN_DEF = 16;
    localparam int HIST_DEPTH     = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 8;

    localparam logic [7:0] OPTION_LIMIT = 8'd10;

    localparam logic [7:0] SYNC_RST        = 8'h55;
    localparam logic [7:0] READY_QUERY_RST = 8'd165;
    localparam logic [7:0] RUNNING_RST     = 8'd1;
    localparam logic [7:0] NOT_RUNNING_RST = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC        = 2'd0,
        CFG_READY_QUERY = 2'd1,
        CFG_RUNNING     = 2'd2,
        CFG_NOT_RUNNING = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] sync_code;
        logic [7:0] ready_query_code;
        logic [7:0] running_code;
        logic [7:0] not_running_code;
    } spr_cfg_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
        logic [7:0] pass_high;
        logic [7:0] pass_mid;
        logic [7:0] pass_low;
        logic [7:0] sensor_position;
    } spr_in_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       option_valid;
        logic [3:0] option_value;
    } spr_out_t;

endpackage

/* rtl/spr_cfg_regs.sv */
// Configuration register file for the SPI sync poll responder.
// Depends on spr_pkg for the register index codes and the config struct.
module spr_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  spr_pkg::cfg_idx_t                    cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]       cfg_data,
    output spr_pkg::spr_cfg_t                    cfg
);
    import spr_pkg::*;

    spr_cfg_t cfg_reg;
    spr_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC:        cfg_next.sync_code        = cfg_data;
                CFG_READY_QUERY: cfg_next.ready_query_code = cfg_data;
                CFG_RUNNING:     cfg_next.running_code     = cfg_data;
                CFG_NOT_RUNNING: cfg_next.not_running_code = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_code        <= SYNC_RST;
            cfg_reg.ready_query_code <= READY_QUERY_RST;
            cfg_reg.running_code     <= RUNNING_RST;
            cfg_reg.not_running_code <= NOT_RUNNING_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/spr_core.sv */
// Rule evaluation and responder state: byte history, write count, ready flag.
// Depends on spr_pkg for the item, result and config structs.
module spr_core #(
    parameter int BUFFER_LEN = spr_pkg::BUFFER_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  spr_pkg::spr_cfg_t  cfg,
    input  logic               step,
    input  spr_pkg::spr_in_t   item,
    output spr_pkg::spr_out_t  result
);
    import spr_pkg::*;

    localparam int CW = $clog2(BUFFER_LEN);

    logic [7:0]    hist_reg  [HIST_DEPTH];
    logic [7:0]    hist_next [HIST_DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          ready_reg;
    logic          ready_next;

    logic [7:0] b;
    logic       cleared;
    logic       full;

    assign b    = item.rx_byte;
    assign full = (count_reg == CW'(BUFFER_LEN - 1));

    always_comb
    begin
        result     = '0;
        cleared    = 1'b0;
        ready_next = ready_reg;
        hist_next  = hist_reg;
        count_next = count_reg;

        if (item.mode)
        begin
            // check finished event: only the flag moves
            ready_next = 1'b1;
        end
        else
        begin
            if (b == cfg.sync_code)
            begin
                result.tx_valid = 1'b1;
                result.tx_byte  = b;
            end
            else if (hist_reg[0] == cfg.sync_code && b < OPTION_LIMIT)
            begin
                result.option_valid = 1'b1;
                result.option_value = b[3:0];
                ready_next          = 1'b0;
                cleared             = 1'b1;
            end
            else if (hist_reg[0] == cfg.sync_code && b == cfg.ready_query_code)
            begin
                result.tx_valid = 1'b1;
                result.tx_byte  = b;
            end
            else if (hist_reg[1] == cfg.sync_code
                     && hist_reg[0] == cfg.ready_query_code)
            begin
                result.tx_valid = 1'b1;
                result.tx_byte  = ready_reg ? cfg.not_running_code : cfg.running_code;
            end
            else if (hist_reg[2] == cfg.sync_code
                     && hist_reg[1] == cfg.ready_query_code)
            begin
                result.tx_valid = 1'b1;
                result.tx_byte  = item.pass_high;
            end
            else if (hist_reg[3] == cfg.sync_code
                     && hist_reg[2] == cfg.ready_query_code)
            begin
                result.tx_valid = 1'b1;
                result.tx_byte  = item.pass_mid;
            end
            else if (hist_reg[4] == cfg.sync_code
                     && hist_reg[3] == cfg.ready_query_code)
            begin
                result.tx_valid = 1'b1;
                result.tx_byte  = item.pass_low;
            end
            else if (hist_reg[5] == cfg.sync_code
                     && hist_reg[4] == cfg.ready_query_code)
            begin
                result.tx_valid = 1'b1;
                result.tx_byte  = item.sensor_position;
                cleared         = 1'b1;
            end

            if (cleared)
            begin
                // command consumed: drop history, count restarts with this byte
                for (int i = 0; i < HIST_DEPTH; i++)
                    hist_next[i] = '0;
                count_next = CW'(1);
            end
            else if (full)
            begin
                for (int i = 0; i < HIST_DEPTH; i++)
                    hist_next[i] = '0;
                count_next = '0;
            end
            else
            begin
                for (int i = HIST_DEPTH - 1; i > 0; i--)
                    hist_next[i] = hist_reg[i-1];
                hist_next[0] = b;
                count_next   = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HIST_DEPTH; i++)
                hist_reg[i] <= '0;
            count_reg <= '0;
            ready_reg <= 1'b0;
        end
        else if (step)
        begin
            hist_reg  <= hist_next;
            count_reg <= count_next;
            ready_reg <= ready_next;
        end
    end

endmodule

/* rtl/spi_sync_poll_responder.sv */
// Top level of the SPI sync poll responder: request register, rule core,
// response register. Depends on spr_pkg, spr_cfg_regs and spr_core.
//
// Usage:
//   Request channel (req_valid / req_stall / req) carries one received SPI
//   byte, or with mode set a check finished event, plus the sensor pass
//   bytes and sensor position to send back when a data reply is due.
//   Response channel (rsp_valid / rsp_stall / rsp) returns exactly one
//   result per request: a reply byte, a check option, or all zero.
//   An accepted request passes through the request register into the
//   response register; one request is taken every cycle unless stalled. The
//   rules run in one pass between the request register and the response
//   register, and the byte history is updated in the same cycle, so
//   consecutive requests see each other.
//   When the receiver stalls, the response register holds; a request
//   already registered then waits and req_stall rises, releasing in the
//   cycle the response is taken.
//   Reset clears the history, write count, ready flag and both valid bits,
//   and loads the configuration defaults. Configuration writes through
//   cfg_we / cfg_index / cfg_data take effect at the next edge and belong
//   only in idle periods.
module spi_sync_poll_responder #(
    parameter int BUFFER_LEN = spr_pkg::BUFFER_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  spr_pkg::spr_in_t                req,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output spr_pkg::spr_out_t               rsp,
    input  logic                            cfg_we,
    input  spr_pkg::cfg_idx_t               cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import spr_pkg::*;

    spr_cfg_t cfg;
    spr_out_t result;

    logic     req_vld_reg;
    logic     req_vld_next;
    spr_in_t  req_data_reg;
    logic     rsp_vld_reg;
    logic     rsp_vld_next;
    spr_out_t rsp_data_reg;

    logic advance;
    logic req_take;

    assign advance   = req_vld_reg && (!rsp_vld_reg || !rsp_stall);
    assign req_stall = req_vld_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    spr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spr_core #(
        .BUFFER_LEN (BUFFER_LEN)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (advance),
        .item   (req_data_reg),
        .result (result)
    );

    always_comb
    begin
        req_vld_next = req_vld_reg;
        if (req_take)
            req_vld_next = 1'b1;
        else if (advance)
            req_vld_next = 1'b0;

        rsp_vld_next = rsp_vld_reg;
        if (advance)
            rsp_vld_next = 1'b1;
        else if (!rsp_stall)
            rsp_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            req_vld_reg <= req_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (req_take)
            req_data_reg <= req;
        if (advance)
            rsp_data_reg <= result;
    end

    assign rsp_valid = rsp_vld_reg;
    assign rsp       = rsp_data_reg;

endmodule

/* rtl/spr_checker.sv */
// Port-level checks for the SPI sync poll responder, bound to the top level.
// Depends on spr_pkg and spi_sync_poll_responder.
module spr_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  spr_pkg::spr_out_t  rsp
);
    import spr_pkg::*;

    // a request yields either a reply byte or an option, never both
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.tx_valid && rsp.option_valid))
        else $error("reply and option in one response");

    a_option_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.option_valid) |-> (rsp.option_value < 4'd10))
        else $error("option value out of range");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> ((rsp.tx_valid || rsp.tx_byte == 8'd0)
                       && (rsp.option_valid || rsp.option_value == 4'd0)))
        else $error("unused response field not zero");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
        else $error("stalled response changed");

endmodule

bind spi_sync_poll_responder spr_checker u_spr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
